@@ hw/rtl/lcdt_pkg.sv @@
// Shared types and constants for the LCD mode and scan-line timing core.
// Used by lcd_mode_line_timing_core and its port checker.
// No dependencies.
`timescale 1ns / 1ps

package lcdt_pkg;

  // Frame geometry
  localparam logic [7:0] VISIBLE_LINES = 8'd144;
  localparam logic [7:0] FINAL_LINE    = 8'd153;

  // Last phase of each mode (mode length minus one)
  localparam logic [6:0] LEN_HBLANK = 7'd50;
  localparam logic [6:0] LEN_VBLANK = 7'd113;
  localparam logic [6:0] LEN_SEARCH = 7'd19;
  localparam logic [6:0] LEN_DRAW   = 7'd42;

  // STAT mode bit codes
  localparam logic [1:0] STAT_HBLANK = 2'd0;
  localparam logic [1:0] STAT_VBLANK = 2'd1;
  localparam logic [1:0] STAT_SEARCH = 2'd2;
  localparam logic [1:0] STAT_DRAW   = 2'd3;

  // Configuration register indexes
  localparam logic [7:0] CFG_HBLANK_IRQ_EN  = 8'd0;
  localparam logic [7:0] CFG_VBLANK_IRQ_EN  = 8'd1;
  localparam logic [7:0] CFG_OAM_IRQ_EN     = 8'd2;
  localparam logic [7:0] CFG_COINC_IRQ_EN   = 8'd3;

  // Input word, first field in the highest bits
  typedef struct packed {
    logic [6:0] pad;
    logic [7:0] line_compare;
    logic       display_enable;
  } in_word_t;

  // Result word, first field in the highest bits
  typedef struct packed {
    logic       begin_drawing;
    logic       begin_search;
    logic       status_irq;
    logic       vblank_irq;
    logic       coincidence_flag;
    logic       display_running;
    logic [1:0] status_mode;
    logic [7:0] current_line;
  } out_word_t;

endpackage

@@ hw/rtl/lcd_mode_line_timing_core.sv @@
// LCD mode and scan-line timing core: one request per machine-cycle tick.
// The result is registered and appears on the master side in the cycle after the request is accepted.
// 1 request per cycle unless a result stalls; the register frees as it is taken.
// The mode, phase and line registers advance once per accepted request.
// Reset (rst, synchronous, active high): sequencer stopped at line 0,
// interrupt enables cleared, result register empty.
`timescale 1ns / 1ps

module lcd_mode_line_timing_core (
  input  logic        clk,
  input  logic        rst,
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic        cfg_data,
  // Tick requests
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] display_enable, [8:1] line_compare, [15:9] zero
  input  logic [15:0] s_axis_tdata,
  // Results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] current_line, [9:8] status_mode, [10] display_running,
  // [11] coincidence_flag, [12] vblank_irq, [13] status_irq,
  // [14] begin_search, [15] begin_drawing
  output logic [15:0] m_axis_tdata
);
  import lcdt_pkg::*;

  typedef enum logic [2:0] {
    SEQ_HBLANK  = 3'd0,
    SEQ_VBLANK  = 3'd1,
    SEQ_SEARCH  = 3'd2,
    SEQ_DRAW    = 3'd3,
    SEQ_STOPPED = 3'd4
  } seq_mode_t;

  // Configuration registers
  logic hblank_irq_enable;
  logic vblank_stat_irq_enable;
  logic oam_irq_enable;
  logic coincidence_irq_enable;

  // Sequencer state
  seq_mode_t  seq_mode, seq_mode_next;
  logic [6:0] phase_count, phase_count_next;
  logic [6:0] phase_limit, phase_limit_next;
  logic [7:0] line_count, line_count_next;
  logic [1:0] mode_bits, mode_bits_next;
  logic       coincidence_bit, coincidence_bit_next;

  // Result register
  logic       out_valid;
  out_word_t  out_word, out_word_next;

  in_word_t   in_word;
  logic       accept;
  logic       go;
  logic [6:0] phase_cur;
  logic       enter;
  seq_mode_t  enter_mode;
  logic       p_vblank, p_status, p_search, p_draw;

  assign in_word       = in_word_t'(s_axis_tdata);
  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_word;

  // Pick the next mode, phase and line for this tick
  always_comb begin
    seq_mode_next        = seq_mode;
    phase_count_next     = phase_count;
    phase_limit_next     = phase_limit;
    line_count_next      = line_count;
    mode_bits_next       = mode_bits;
    coincidence_bit_next = coincidence_bit;
    go                   = 1'b0;
    phase_cur            = phase_count;
    enter                = 1'b0;
    enter_mode           = SEQ_SEARCH;
    p_vblank             = 1'b0;
    p_status             = 1'b0;
    p_search             = 1'b0;
    p_draw               = 1'b0;

    // Start, stop or run
    if (seq_mode == SEQ_STOPPED) begin
      if (in_word.display_enable) begin
        go        = 1'b1;
        phase_cur = '0;
      end
    end else if (!in_word.display_enable) begin
      seq_mode_next = SEQ_STOPPED;
    end else begin
      go = 1'b1;
    end

    // Mode transitions at phase zero
    if (go && phase_cur == '0) begin
      case (seq_mode)
        SEQ_STOPPED: begin
          line_count_next = '0;
          enter           = 1'b1;
          enter_mode      = SEQ_SEARCH;
        end
        SEQ_HBLANK: begin
          line_count_next = line_count + 8'd1;
          enter           = 1'b1;
          enter_mode      = (line_count_next < VISIBLE_LINES) ? SEQ_SEARCH : SEQ_VBLANK;
        end
        SEQ_VBLANK: begin
          if (line_count < FINAL_LINE) begin
            line_count_next = line_count + 8'd1;
          end else begin
            line_count_next = '0;
            enter           = 1'b1;
            enter_mode      = SEQ_SEARCH;
          end
        end
        SEQ_SEARCH: begin
          enter      = 1'b1;
          enter_mode = SEQ_DRAW;
        end
        default: begin
          enter      = 1'b1;
          enter_mode = SEQ_HBLANK;
        end
      endcase
    end

    // Mode entry: limits, mode bits, coincidence check and pulses
    if (enter) begin
      seq_mode_next  = enter_mode;
      mode_bits_next = enter_mode[1:0];
      case (enter_mode)
        SEQ_HBLANK: begin
          phase_limit_next = LEN_HBLANK;
          p_status         = hblank_irq_enable;
        end
        SEQ_VBLANK: begin
          phase_limit_next     = LEN_VBLANK;
          coincidence_bit_next = (line_count_next == in_word.line_compare);
          p_vblank             = 1'b1;
          p_status             = vblank_stat_irq_enable
                                 || (coincidence_bit_next && coincidence_irq_enable);
        end
        SEQ_SEARCH: begin
          phase_limit_next     = LEN_SEARCH;
          coincidence_bit_next = (line_count_next == in_word.line_compare);
          p_search             = 1'b1;
          p_status             = oam_irq_enable
                                 || (coincidence_bit_next && coincidence_irq_enable);
        end
        default: begin
          phase_limit_next = LEN_DRAW;
          p_draw           = 1'b1;
        end
      endcase
    end

    // Advance the phase, wrapping after the limit
    if (go) begin
      phase_count_next = (phase_cur >= phase_limit_next) ? '0 : phase_cur + 7'd1;
    end

    out_word_next.current_line     = line_count_next;
    out_word_next.status_mode      = mode_bits_next;
    out_word_next.display_running  = (seq_mode_next != SEQ_STOPPED);
    out_word_next.coincidence_flag = coincidence_bit_next;
    out_word_next.vblank_irq       = p_vblank;
    out_word_next.status_irq       = p_status;
    out_word_next.begin_search     = p_search;
    out_word_next.begin_drawing    = p_draw;
  end

  // Hold sequencer, configuration and result state
  always_ff @(posedge clk) begin
    if (rst) begin
      hblank_irq_enable      <= 1'b0;
      vblank_stat_irq_enable <= 1'b0;
      oam_irq_enable         <= 1'b0;
      coincidence_irq_enable <= 1'b0;
      seq_mode               <= SEQ_STOPPED;
      phase_count            <= '0;
      phase_limit            <= '0;
      line_count             <= '0;
      mode_bits              <= '0;
      coincidence_bit        <= 1'b0;
      out_valid              <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_HBLANK_IRQ_EN: hblank_irq_enable      <= cfg_data;
          CFG_VBLANK_IRQ_EN: vblank_stat_irq_enable <= cfg_data;
          CFG_OAM_IRQ_EN:    oam_irq_enable         <= cfg_data;
          CFG_COINC_IRQ_EN:  coincidence_irq_enable <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        seq_mode        <= seq_mode_next;
        phase_count     <= phase_count_next;
        phase_limit     <= phase_limit_next;
        line_count      <= line_count_next;
        mode_bits       <= mode_bits_next;
        coincidence_bit <= coincidence_bit_next;
        out_valid       <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load the result word
  always_ff @(posedge clk) begin
    if (accept) begin
      out_word <= out_word_next;
    end
  end

endmodule

@@ hw/rtl/lcdt_port_checker.sv @@
// Port-level checker for lcd_mode_line_timing_core, bound into each instance of the core.
// Depends on lcdt_pkg for the result word layout and frame constants.
`timescale 1ns / 1ps

module lcdt_port_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);
  import lcdt_pkg::*;

  out_word_t res;
  assign res = out_word_t'(m_axis_tdata);

  // Result channel comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // Stalled result holds its value
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Stopped sequencer raises no pulses
  a_stopped_quiet: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !res.display_running |->
      !res.vblank_irq && !res.status_irq && !res.begin_search && !res.begin_drawing)
    else $error("pulse while display stopped");

  // Entry pulses agree with the reported mode
  a_pulse_mode: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      (!res.begin_search || res.status_mode == STAT_SEARCH) &&
      (!res.begin_drawing || res.status_mode == STAT_DRAW) &&
      (!res.vblank_irq || res.status_mode == STAT_VBLANK))
    else $error("entry pulse does not match mode");

  // Line counter never passes the final line
  a_line_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> res.current_line <= FINAL_LINE)
    else $error("line counter out of range");

endmodule

bind lcd_mode_line_timing_core lcdt_port_checker u_lcdt_port_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ bench/lcd_mode_line_timing_core_tb.sv @@
// Self-checking bench for lcd_mode_line_timing_core: streams tick requests, predicts
// every result with a cycle-level timing predictor and compares it field by field.
// Depends on lcdt_pkg and the lcd_mode_line_timing_core RTL.
`timescale 1ns / 1ps

module lcd_mode_line_timing_core_tb;
  import lcdt_pkg::*;

  // Ticks per scan line and per frame
  localparam int LINE_TICKS     = int'(LEN_VBLANK) + 1;
  localparam int FRAME_TICKS    = (int'(FINAL_LINE) + 1) * LINE_TICKS;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_PRINTS     = 50;
  // Interrupt enable sets per phase, one nibble each, phase 0 in the low bits
  localparam logic [31:0] PHASE_SETS = 32'hA008421F;
  localparam int NUM_PHASES = 8;

  typedef enum logic [2:0] {
    M_HBLANK = 3'd0,
    M_VBLANK = 3'd1,
    M_SEARCH = 3'd2,
    M_DRAW   = 3'd3,
    M_OFF    = 3'd4
  } seq_state_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic        cfg_data = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [0] display_enable, [8:1] line_compare, [15:9] zero
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [7:0] current_line, [9:8] status_mode, [10] display_running,
  // [11] coincidence_flag, [12] vblank_irq, [13] status_irq,
  // [14] begin_search, [15] begin_drawing
  logic [15:0] m_axis_tdata;

  lcd_mode_line_timing_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Pending tick requests and results still owed by the block
  in_word_t  tick_q [$];
  out_word_t timing_q [$];

  int err_cnt     = 0;
  int res_cnt     = 0;
  int sent_cnt    = 0;
  int taken_cnt   = 0;
  int quiet_cycles = 0;
  int gen_tick    = 0;   // ticks since the sequencer last started, as seen by the generator

  // Predictor state
  seq_state_t  seq_st  = M_OFF;
  logic [6:0]  ph_cnt  = '0;
  logic [6:0]  ph_lim  = '0;
  logic [7:0]  line_q  = '0;
  logic [1:0]  stat_q  = STAT_HBLANK;
  logic        coinc_q = 1'b0;
  logic        irq_en [0:3] = '{1'b0, 1'b0, 1'b0, 1'b0};
  logic        pulse_vbl, pulse_stat, pulse_search, pulse_draw;

  task automatic report_mismatch(string msg);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS)
      $display("ERROR result %0d: %s", res_cnt, msg);
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // Enter a mode: set STAT bits, phase limit, pulses and the line check
  function automatic void enter_mode(seq_state_t m, logic [7:0] cmp);
    seq_st = m;
    case (m)
      M_HBLANK: begin
        stat_q = STAT_HBLANK;
        ph_lim = LEN_HBLANK;
        if (irq_en[CFG_HBLANK_IRQ_EN[1:0]]) pulse_stat = 1'b1;
      end
      M_VBLANK: begin
        stat_q = STAT_VBLANK;
        ph_lim = LEN_VBLANK;
        coinc_q = (line_q == cmp);
        if (coinc_q && irq_en[CFG_COINC_IRQ_EN[1:0]]) pulse_stat = 1'b1;
        pulse_vbl = 1'b1;
        if (irq_en[CFG_VBLANK_IRQ_EN[1:0]]) pulse_stat = 1'b1;
      end
      M_SEARCH: begin
        stat_q = STAT_SEARCH;
        ph_lim = LEN_SEARCH;
        coinc_q = (line_q == cmp);
        if (coinc_q && irq_en[CFG_COINC_IRQ_EN[1:0]]) pulse_stat = 1'b1;
        if (irq_en[CFG_OAM_IRQ_EN[1:0]]) pulse_stat = 1'b1;
        pulse_search = 1'b1;
      end
      default: begin
        stat_q = STAT_DRAW;
        ph_lim = LEN_DRAW;
        pulse_draw = 1'b1;
      end
    endcase
  endfunction

  // Advance the timing state by one tick and return the result it produces
  function automatic out_word_t step_timing(logic en, logic [7:0] cmp);
    out_word_t r;
    logic      go;
    go = 1'b1;
    pulse_vbl = 1'b0;
    pulse_stat = 1'b0;
    pulse_search = 1'b0;
    pulse_draw = 1'b0;
    if (seq_st == M_OFF) begin
      if (!en) go = 1'b0;
      else ph_cnt = '0;
    end else if (!en) begin
      seq_st = M_OFF;
      go = 1'b0;
    end
    if (go) begin
      if (ph_cnt == '0) begin
        case (seq_st)
          M_OFF: begin
            line_q = '0;
            enter_mode(M_SEARCH, cmp);
          end
          M_HBLANK: begin
            line_q = line_q + 8'd1;
            if (line_q < VISIBLE_LINES) enter_mode(M_SEARCH, cmp);
            else enter_mode(M_VBLANK, cmp);
          end
          M_VBLANK: begin
            // Vertical blank lines step without re-entering the mode
            if (line_q < FINAL_LINE) begin
              line_q = line_q + 8'd1;
            end else begin
              line_q = '0;
              enter_mode(M_SEARCH, cmp);
            end
          end
          M_SEARCH: enter_mode(M_DRAW, cmp);
          default:  enter_mode(M_HBLANK, cmp);
        endcase
      end
      if (ph_cnt >= ph_lim) ph_cnt = '0;
      else ph_cnt = ph_cnt + 7'd1;
    end
    r = '0;
    r.current_line     = line_q;
    r.status_mode      = stat_q;
    r.display_running  = (seq_st != M_OFF);
    r.coincidence_flag = coinc_q;
    r.vblank_irq       = pulse_vbl;
    r.status_irq       = pulse_stat;
    r.begin_search     = pulse_search;
    r.begin_drawing    = pulse_draw;
    return r;
  endfunction

  // Queue one tick; a negative compare picks the current line or a random value
  task automatic push_tick(logic en, int cmp);
    in_word_t w;
    int       f;
    w = '0;
    w.display_enable = en;
    if (cmp >= 0) begin
      w.line_compare = cmp[7:0];
    end else if (en && $urandom_range(0, 2) == 0) begin
      f = gen_tick % FRAME_TICKS;
      w.line_compare = 8'(f / LINE_TICKS);
    end else begin
      w.line_compare = 8'($urandom_range(0, 255));
    end
    if (en) gen_tick++;
    else gen_tick = 0;
    tick_q = {tick_q, w};
  endtask

  // Mostly enabled runs with random content, some display-off noise in between
  task automatic gen_random(int n);
    int made;
    int len;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 4) != 0) begin
        len = $urandom_range(10, 40);
        if (len > n - made) len = n - made;
        repeat (len) push_tick(1'b1, -1);
      end else begin
        len = $urandom_range(1, 4);
        repeat (len) push_tick(1'b0, -1);
      end
      made += len;
    end
  endtask

  // Hold until no request is queued, in flight or owed
  task automatic wait_idle();
    while (tick_q.size() != 0 || s_axis_tvalid || timing_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx <= CFG_COINC_IRQ_EN) irq_en[idx[1:0]] = d;
  endtask

  // Write all enables, then an index past the last register
  task automatic apply_setting(logic [3:0] bits);
    for (int r = 0; r < 4; r++)
      write_reg(8'(CFG_HBLANK_IRQ_EN + r), bits[r]);
    write_reg(8'(CFG_COINC_IRQ_EN + 1 + $urandom_range(0, 251)), 1'($urandom_range(0, 1)));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Sender: bursts of random length separated by random gaps
  int tx_burst = 0;
  int tx_gap   = 0;

  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && taken_cnt != sent_cnt) begin
      // hold the request until it is taken
    end else begin
      if (tx_burst == 0) begin
        tx_gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        tx_burst = ($urandom_range(0, 5) == 0) ? 300 : $urandom_range(1, 40);
      end
      if (tx_gap != 0) begin
        tx_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (tick_q.size() != 0) begin
        s_axis_tdata  <= tick_q.pop_front();
        s_axis_tvalid <= 1'b1;
        sent_cnt++;
        tx_burst--;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern picked per window (none, random, periodic, long holds)
  int         rx_window = 0;
  int         rx_kind   = 0;
  int         rx_hold   = 0;
  logic [1:0] rx_phase  = '0;

  always @(negedge clk) begin
    if (rx_window == 0) begin
      rx_kind   = $urandom_range(0, 3);
      rx_window = $urandom_range(20, 300);
    end else begin
      rx_window--;
    end
    rx_phase = rx_phase + 2'd1;
    case (rx_kind)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 2) != 0);
      2: m_axis_tready <= (rx_phase != 2'd3);
      default: begin
        if (rx_hold != 0) begin
          rx_hold--;
          m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
          rx_hold = $urandom_range(1, 12);
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    endcase
  end

  // Monitor: check each result, then predict for each accepted request
  always @(posedge clk) begin : monitor
    out_word_t got;
    out_word_t want;
    out_word_t pred;
    in_word_t  tick_in;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (timing_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0h", m_axis_tdata));
        end else begin
          want = timing_q.pop_front();
          check_field("current_line", got.current_line, want.current_line);
          check_field("status_mode", 8'(got.status_mode), 8'(want.status_mode));
          check_field("display_running", 8'(got.display_running), 8'(want.display_running));
          check_field("coincidence_flag", 8'(got.coincidence_flag),
                      8'(want.coincidence_flag));
          check_field("vblank_irq", 8'(got.vblank_irq), 8'(want.vblank_irq));
          check_field("status_irq", 8'(got.status_irq), 8'(want.status_irq));
          check_field("begin_search", 8'(got.begin_search), 8'(want.begin_search));
          check_field("begin_drawing", 8'(got.begin_drawing), 8'(want.begin_drawing));
        end
        res_cnt++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        tick_in = s_axis_tdata;
        pred = step_timing(tick_in.display_enable, tick_in.line_compare);
        timing_q = {timing_q, pred};
        taken_cnt++;
      end
    end
  end

  // Watchdog: end the run when no handshake happens for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [3:0] bits;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: idle ticks, start with coincidence at line 0, stop, hold, restart
    apply_setting(4'b0000);
    push_tick(1'b0, 255);
    push_tick(1'b0, 0);
    push_tick(1'b1, 0);
    push_tick(1'b1, 255);
    push_tick(1'b1, 0);
    push_tick(1'b0, 8'h55);
    push_tick(1'b0, 8'hAA);
    push_tick(1'b1, 1);
    repeat (22) push_tick(1'b1, -1);
    wait_idle();

    // Phases: each enable set and a random one, some starting from display off
    for (int p = 0; p < NUM_PHASES; p++) begin
      bits = PHASE_SETS[p*4 +: 4];
      if (p == 5) bits = 4'($urandom_range(0, 15));
      apply_setting(bits);
      if (p == 0 || p == NUM_PHASES - 1) begin
        push_tick(1'b0, -1);
      end
      gen_random(65);
      wait_idle();
    end

    if (err_cnt == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
